[hw/rtl/chol_pkg.sv]
// Shared types and constants of the Cholesky positive-definiteness checker.
// No dependencies; every other RTL file imports this package.
`default_nettype none
package chol_pkg;
	localparam int MAX_ORDER = 8;
	localparam int IDX_W     = $clog2(MAX_ORDER);
	localparam int ORD_W     = 4;
	localparam int CNT_W     = $clog2(MAX_ORDER * MAX_ORDER + 1);
	localparam int DATA_W    = 32;
	localparam int ACC_W     = 48;
	localparam int WIDE_W    = 64;
	localparam int TOL_W     = 31;
	localparam int CFGI_W    = 1;

	localparam logic [CFGI_W-1:0] CFG_SIZE = 1'b0;
	localparam logic [CFGI_W-1:0] CFG_MIND = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_PIVOT = 2'd1,
		STAT_TOL   = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_LOAD, ST_FETCH, ST_AINIT, ST_LRD, ST_MUL, ST_ACC,
		ST_FINISH, ST_WAIT, ST_RESULT
	} state_t;

	typedef enum logic {
		OP_SQRT = 1'b0,
		OP_DIV  = 1'b1
	} iter_op_t;

	typedef struct packed {
		logic     start;
		iter_op_t op;
	} iter_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} iter_rsp_t;
endpackage
`default_nettype wire

[hw/rtl/chol_ifs.sv]
// Valid/ready channel interfaces for matrix elements in and check results out.
// Depends on chol_pkg.
`default_nettype none
interface chol_in_if import chol_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] matrix_element;
	logic                     last;
	modport source (output valid, matrix_element, last, input ready);
	modport sink   (input valid, matrix_element, last, output ready);
endinterface

interface chol_out_if import chol_pkg::*; ();
	logic       valid;
	logic       ready;
	logic       is_spd;
	logic [1:0] status;
	modport source (output valid, is_spd, status, input ready);
	modport sink   (input valid, is_spd, status, output ready);
endinterface
`default_nettype wire

[hw/rtl/cholesky_spd_check_unit.sv]
// Top level of the Cholesky positive-definiteness checker.
// Depends on chol_pkg, chol_ifs (chol_in_if, chol_out_if) and chol_iter_unit.
//
// Usage: write size_in_use (index 0, order n, 0 acts as 1, above 8 acts as 8)
// and min_diagonal (index 1, Q16.16) while idle, then stream the n*n matrix
// in row-major order, one Q16.16 transaction per cycle, last set on the
// final element. Only the lower triangle is used; extra elements are dropped.
// After last the input stalls while the factorization runs on one shared
// 32x32 multiplier plus one iterative sqrt/divide unit. Per column j the
// diagonal needs a 32-step square root and each off-diagonal below it a
// 64-step division, each after a j-term multiply-accumulate. Exactly one
// result transaction follows each last element: is_spd and status (ok /
// non-positive pivot / diagonal of L not above tolerance). Input is refused
// until the result is taken.
`default_nettype none
module cholesky_spd_check_unit import chol_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	chol_in_if.sink                in_ch,
	chol_out_if.source             out_ch,
	input  wire logic              cfg_we,
	input  wire logic [CFGI_W-1:0] cfg_index,
	input  wire logic [TOL_W-1:0]  cfg_wdata
);
	localparam logic signed [ACC_W-1:0]  SAT_POS = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0]  SAT_NEG = -SAT_POS;
	localparam logic signed [DATA_W-1:0] LMAX    = {1'b0, {(DATA_W-1){1'b1}}};

	// ---- configuration ----
	logic [ORD_W-1:0] size_q;
	logic [TOL_W-1:0] mind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= ORD_W'(6);
			mind_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SIZE: size_q <= cfg_wdata[ORD_W-1:0];
				CFG_MIND: mind_q <= cfg_wdata;
				default:  ;
			endcase
		end
	end

	// effective order, clamped to 1..MAX_ORDER
	logic [ORD_W-1:0] n_eff;
	logic [CNT_W-1:0] nn;
	always_comb begin
		if (size_q == '0)
			n_eff = ORD_W'(1);
		else if (size_q > ORD_W'(MAX_ORDER))
			n_eff = ORD_W'(MAX_ORDER);
		else
			n_eff = size_q;
	end
	assign nn = CNT_W'(CNT_W'(n_eff) * CNT_W'(n_eff));

	// row = count / n by compare against multiples of n (count stays small)
	function automatic logic [IDX_W-1:0] row_of(input logic [CNT_W-1:0] c,
			input logic [ORD_W-1:0] n);
		logic [IDX_W-1:0] r;
		r = '0;
		for (int m = 1; m < MAX_ORDER; m++)
			if (c >= CNT_W'(CNT_W'(m) * CNT_W'(n)))
				r = r + IDX_W'(1);
		return r;
	endfunction

	function automatic logic signed [ACC_W-1:0] sat_sub(input logic signed [ACC_W-1:0] a,
			input logic signed [ACC_W-1:0] b);
		logic signed [ACC_W:0] d;
		d = {a[ACC_W-1], a} - {b[ACC_W-1], b};
		if (d > $signed({SAT_POS[ACC_W-1], SAT_POS}))
			return SAT_POS;
		else if (d < $signed({SAT_NEG[ACC_W-1], SAT_NEG}))
			return SAT_NEG;
		else
			return d[ACC_W-1:0];
	endfunction

	// ---- state ----
	state_t state_q, state_d;
	logic [CNT_W-1:0]         count_q;
	logic [IDX_W-1:0]         i_q, j_q, k_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [WIDE_W-1:0] prod_s1;
	logic signed [DATA_W-1:0] ldiag_q;
	logic                     tol_fail_q;
	status_t                  status_q;

	logic [DATA_W-1:0] a_mem [MAX_ORDER*MAX_ORDER];
	logic [DATA_W-1:0] l_mem [MAX_ORDER*MAX_ORDER];
	logic [DATA_W-1:0] a_rd_q, li_rd_q, lj_rd_q;

	iter_req_t         it_req;
	iter_rsp_t         it_rsp;
	logic [WIDE_W-1:0] it_operand, it_result;

	logic in_fire, out_fire, diag, pivot_bad, all_done;
	logic [IDX_W-1:0] wr_row, wr_col;
	logic [ACC_W-1:0] mag;
	logic signed [DATA_W-1:0] lval;

	assign in_fire  = in_ch.valid && in_ch.ready;
	assign out_fire = out_ch.valid && out_ch.ready;
	assign diag     = (i_q == j_q);
	assign pivot_bad = diag && (acc_q <= 0);
	assign all_done = diag && (ORD_W'(j_q) + ORD_W'(1) == n_eff);
	assign wr_row   = row_of(count_q, n_eff);
	assign wr_col   = IDX_W'(count_q - CNT_W'(CNT_W'(wr_row) * CNT_W'(n_eff)));
	assign mag      = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);

	// new L entry from the iterative unit, saturated
	always_comb begin
		if (diag) begin
			lval = (it_result > WIDE_W'(LMAX)) ? LMAX : DATA_W'(it_result);
		end else if (acc_q[ACC_W-1]) begin
			lval = (it_result > (WIDE_W'(1) << (DATA_W-1))) ? ~LMAX : DATA_W'(-it_result);
		end else begin
			lval = (it_result > WIDE_W'(LMAX)) ? LMAX : DATA_W'(it_result);
		end
	end

	// ---- next state ----
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD:   if (in_fire && in_ch.last) state_d = ST_FETCH;
			ST_FETCH:  state_d = ST_AINIT;
			ST_AINIT:  state_d = (j_q != '0) ? ST_LRD : ST_FINISH;
			ST_LRD:    state_d = ST_MUL;
			ST_MUL:    state_d = ST_ACC;
			ST_ACC:    state_d = (k_q + IDX_W'(1) == j_q) ? ST_FINISH : ST_LRD;
			ST_FINISH: state_d = pivot_bad ? ST_RESULT : ST_WAIT;
			ST_WAIT:   if (it_rsp.done) state_d = all_done ? ST_RESULT : ST_FETCH;
			ST_RESULT: if (out_fire) state_d = ST_LOAD;
			default:   state_d = ST_LOAD;
		endcase
	end

	// ---- outputs ----
	always_comb begin
		in_ch.ready   = (state_q == ST_LOAD);
		out_ch.valid  = (state_q == ST_RESULT);
		out_ch.status = status_q;
		out_ch.is_spd = (status_q == STAT_OK);
		it_req.start  = (state_q == ST_FINISH) && !pivot_bad;
		it_req.op     = diag ? OP_SQRT : OP_DIV;
		it_operand    = {mag, 16'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			count_q    <= '0;
			i_q        <= '0;
			j_q        <= '0;
			k_q        <= '0;
			tol_fail_q <= 1'b0;
			status_q   <= STAT_OK;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_LOAD: if (in_fire) begin
					if (count_q < nn)
						count_q <= count_q + CNT_W'(1);
					if (in_ch.last) begin
						i_q        <= '0;
						j_q        <= '0;
						tol_fail_q <= 1'b0;
					end
				end
				ST_AINIT: k_q <= '0;
				ST_ACC:   k_q <= k_q + IDX_W'(1);
				ST_FINISH: if (pivot_bad) status_q <= STAT_PIVOT;
				ST_WAIT: if (it_rsp.done) begin
					if (diag) begin
						if ({1'b0, mind_q} >= lval)
							tol_fail_q <= 1'b1;
						if (all_done)
							status_q <= (tol_fail_q || ({1'b0, mind_q} >= lval)) ?
								STAT_TOL : STAT_OK;
						else
							i_q <= i_q + IDX_W'(1);
					end else if (ORD_W'(i_q) + ORD_W'(1) < n_eff) begin
						i_q <= i_q + IDX_W'(1);
					end else begin
						i_q <= j_q + IDX_W'(1);
						j_q <= j_q + IDX_W'(1);
					end
				end
				ST_RESULT: if (out_fire) count_q <= '0;
				default: ;
			endcase
		end
	end

	// ---- datapath ----
	always_ff @(posedge clk) begin
		a_rd_q  <= a_mem[{i_q, j_q}];
		li_rd_q <= l_mem[{i_q, k_q}];
		lj_rd_q <= l_mem[{j_q, k_q}];
		if (in_fire && count_q < nn)
			a_mem[{wr_row, wr_col}] <= in_ch.matrix_element;
		if (state_q == ST_WAIT && it_rsp.done) begin
			l_mem[{i_q, j_q}] <= lval;
			if (diag)
				ldiag_q <= lval;
		end
		if (state_q == ST_AINIT)
			acc_q <= ACC_W'($signed(a_rd_q));
		if (state_q == ST_MUL)
			prod_s1 <= $signed(li_rd_q) * $signed(lj_rd_q);
		if (state_q == ST_ACC)
			acc_q <= sat_sub(acc_q, ACC_W'(prod_s1 >>> 16));
	end

	chol_iter_unit u_iter (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (it_req),
		.operand (it_operand),
		.divisor (ldiag_q),
		.rsp     (it_rsp),
		.result  (it_result)
	);

	// ---- assertions ----
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ch.ready && out_ch.valid)) else $error("input open while result pending");
	a_flag_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.is_spd == (out_ch.status == STAT_OK)))
		else $error("is_spd disagrees with status");
	a_count_rng: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= nn || !in_ch.ready) else $error("element count beyond n*n");
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_ch.valid) |-> ($past(state_q) == ST_WAIT || $past(state_q) == ST_FINISH))
		else $error("result without finished factorization");
	a_unit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		it_req.start |-> !it_rsp.busy) else $error("iterative unit restarted while busy");
endmodule
`default_nettype wire

[hw/rtl/chol_iter_unit.sv]
// Shared shift-and-subtract unit: integer square root (32 steps) or
// unsigned 64/32 restoring division (64 steps), one step per cycle. Uses chol_pkg.
`default_nettype none
module chol_iter_unit import chol_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire iter_req_t         req,
	input  wire logic [WIDE_W-1:0] operand,
	input  wire logic [DATA_W-1:0] divisor,
	output iter_rsp_t              rsp,
	output logic      [WIDE_W-1:0] result
);
	localparam logic [5:0] SQRT_LAST = 6'd31;
	localparam logic [5:0] DIV_LAST  = 6'd63;

	logic              busy_q, done_q;
	iter_op_t          op_q;
	logic [5:0]        cnt_q;
	logic [WIDE_W-1:0] x_q, res_q, bit_q;
	logic [DATA_W-1:0] rem_q, dvs_q;

	logic [WIDE_W-1:0] sq_trial;
	logic              sq_ge;
	logic [DATA_W:0]   dv_trial;
	logic              dv_ge;
	logic              last_step;

	assign sq_trial  = res_q + bit_q;
	assign sq_ge     = (x_q >= sq_trial);
	assign dv_trial  = {rem_q, x_q[WIDE_W-1]};
	assign dv_ge     = (dv_trial >= {1'b0, dvs_q});
	assign last_step = (op_q == OP_SQRT) ? (cnt_q == SQRT_LAST) : (cnt_q == DIV_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= OP_SQRT;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				op_q   <= req.op;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (last_step) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			x_q   <= operand;
			res_q <= '0;
			bit_q <= WIDE_W'(64'h4000_0000_0000_0000);
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (op_q == OP_SQRT) begin
				if (sq_ge) begin
					x_q   <= x_q - sq_trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end else begin
				x_q   <= {x_q[WIDE_W-2:0], dv_ge};
				rem_q <= dv_ge ? DATA_W'(dv_trial - {1'b0, dvs_q}) : dv_trial[DATA_W-1:0];
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign result   = (op_q == OP_SQRT) ? res_q : x_q;
endmodule
`default_nettype wire
